/* hw/rtl/msrs_pkg.sv */
// Package for the multi-stream rate scheduler: sizes, time constants and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none

package msrs_pkg;

    localparam int NUM_STREAMS   = 5;
    localparam int IDX_W         = 3;
    localparam int TIME_W        = 32;
    localparam int RATE_W        = 16;
    localparam int MS_PER_SECOND = 1000;
    // Elapsed time below one second fits in this many bits
    localparam int ELAPSED_W     = 10;
    localparam int PROD_W        = ELAPSED_W + 1 + RATE_W;
    localparam int OUT_BYTES_W   = 8;

    typedef struct packed {
        logic             load_now;
        logic             sub;
        logic             cmp;
        logic             load_out;
        logic [IDX_W-1:0] idx;
    } msrs_cmd_t;

    typedef struct packed {
        logic out_busy;
    } msrs_status_t;

endpackage

`default_nettype wire

/* hw/rtl/msrs_ctrl.sv */
// Controller for the multi-stream rate scheduler: walks the five streams,
// two steps each, and hands the flags to the output register.
// Depends on msrs_pkg.
`default_nettype none

module msrs_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    output msrs_pkg::msrs_cmd_t        cmd,
    input  wire msrs_pkg::msrs_status_t status
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUB  = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [msrs_pkg::IDX_W-1:0] LAST_IDX =
        msrs_pkg::IDX_W'(msrs_pkg::NUM_STREAMS - 1);

    logic [1:0]                 state_reg, state_next;
    logic [msrs_pkg::IDX_W-1:0] idx_reg, idx_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.idx      = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_now = 1'b1;
                    idx_next     = '0;
                    state_next   = ST_SUB;
                end
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SUB;
                end
            end
            ST_DONE:
            begin
                // hold the flags until the output register frees up
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_IDX)
        else $error("stream index out of range");

    a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP && idx_reg == LAST_IDX) |=> state_reg == ST_DONE)
        else $error("last stream did not finish the tick");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.out_busy)
        else $error("output overwritten while stalled");

    a_sub_then_cmp: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sub |=> (cmd.cmp && $stable(idx_reg)))
        else $error("compare step did not follow subtract step");

endmodule

`default_nettype wire

/* hw/rtl/msrs_datapath.sv */
// Datapath for the multi-stream rate scheduler: rate registers, last-fire
// times, elapsed-time subtract, rate multiply-compare and output register.
// Depends on msrs_pkg.
`default_nettype none

module msrs_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [msrs_pkg::TIME_W-1:0]         now_ms,
    input  wire logic                                cfg_valid,
    input  wire logic [msrs_pkg::IDX_W-1:0]          cfg_index,
    input  wire logic [msrs_pkg::RATE_W-1:0]         cfg_data,
    input  wire msrs_pkg::msrs_cmd_t                 cmd,
    output msrs_pkg::msrs_status_t                   status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [msrs_pkg::OUT_BYTES_W-1:0]         m_tdata
);

    logic [msrs_pkg::RATE_W-1:0]      rate_reg [msrs_pkg::NUM_STREAMS];
    logic [msrs_pkg::TIME_W-1:0]      last_reg [msrs_pkg::NUM_STREAMS];
    logic [msrs_pkg::TIME_W-1:0]      now_reg;
    logic [msrs_pkg::ELAPSED_W-1:0]   elapsed_reg;
    logic                             late_reg;
    logic [msrs_pkg::NUM_STREAMS-1:0] flags_reg;
    logic                             out_valid_reg;
    logic [msrs_pkg::NUM_STREAMS-1:0] out_flags_reg;

    logic [msrs_pkg::TIME_W-1:0]      elapsed;
    logic [msrs_pkg::ELAPSED_W:0]     elapsed_inc;
    logic [msrs_pkg::PROD_W-1:0]      prod;
    logic [msrs_pkg::RATE_W-1:0]      rate_sel;
    logic                             fire;

    assign elapsed  = now_reg - last_reg[cmd.idx];
    assign rate_sel = rate_reg[cmd.idx];

    // elapsed >= 1000/rate  <=>  (elapsed + 1) * rate > 1000 for elapsed below 1000
    assign elapsed_inc = {1'b0, elapsed_reg} + 1'b1;
    assign prod = msrs_pkg::PROD_W'(elapsed_inc) * msrs_pkg::PROD_W'(rate_sel);
    assign fire = (rate_sel != '0) &&
                  (late_reg || (prod > msrs_pkg::PROD_W'(msrs_pkg::MS_PER_SECOND)));

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = msrs_pkg::OUT_BYTES_W'(out_flags_reg);
    assign status.out_busy = out_valid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < msrs_pkg::NUM_STREAMS; k++)
            begin
                rate_reg[k] <= '0;
                last_reg[k] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // drop writes beyond the last stream
            if (cfg_valid && (cfg_index < msrs_pkg::IDX_W'(msrs_pkg::NUM_STREAMS)))
            begin
                rate_reg[cfg_index] <= cfg_data;
            end
            if (cmd.cmp && fire)
            begin
                last_reg[cmd.idx] <= now_reg;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_now)
        begin
            now_reg <= now_ms;
        end
        if (cmd.sub)
        begin
            late_reg    <= (elapsed >= msrs_pkg::TIME_W'(msrs_pkg::MS_PER_SECOND));
            elapsed_reg <= elapsed[msrs_pkg::ELAPSED_W-1:0];
        end
        if (cmd.cmp)
        begin
            flags_reg[cmd.idx] <= fire;
        end
        if (cmd.load_out)
        begin
            out_flags_reg <= flags_reg;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/multi_stream_rate_scheduler.sv */
// Five-stream periodic rate scheduler.
//
// Slave stream: one word per update tick; s_tdata carries now_ms, the current
// time in milliseconds. Master stream: one word per tick; m_tdata carries one
// fire flag per stream. Configuration channel: cfg_index selects the rate
// register (0 extended status, 1 position, 2 attitude, 3 HUD, 4 extra EKF),
// cfg_data the rate in hertz; zero disables a stream, other indexes are
// ignored. cfg_ready is always high; write only while no tick is in flight.
//
// A tick runs as the accept step, then two steps per stream on the
// single shared subtract and multiply-compare path (elapsed time, then the
// period test), then a step to load the output register, which drives
// m_tvalid; s_tready is high only between ticks, so a new tick is not
// accepted until the last one has loaded the output register.
// When the receiver stalls, the result holds in the output register and the
// next tick is still accepted and worked; it waits at the end until the
// register is taken. Reset clears all rates and last-fire times to zero.
//
// Depends on msrs_pkg, msrs_ctrl and msrs_datapath.
`default_nettype none

module multi_stream_rate_scheduler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [msrs_pkg::TIME_W-1:0]   s_tdata,   // [31:0] now_ms
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] fire_extended_status, [1] fire_position, [2] fire_attitude,
    // [3] fire_hud, [4] fire_ekf_extra, [7:5] zero
    output logic [msrs_pkg::OUT_BYTES_W-1:0]   m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [msrs_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [msrs_pkg::RATE_W-1:0]   cfg_data
);

    msrs_pkg::msrs_cmd_t    cmd;
    msrs_pkg::msrs_status_t status;

    assign cfg_ready = 1'b1;

    msrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    msrs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .now_ms    (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
